// ===== hdl/tcp_mss_clamp_macros.svh =====
// Assertion macros used by the checker file of the MSS clamp block.
`ifndef TCP_MSS_CLAMP_MACROS_SVH
`define TCP_MSS_CLAMP_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define TMC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcp_mss_clamp: check failed");

// The antecedent implies the consequent in the next cycle.
`define TMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcp_mss_clamp: check failed");

`endif

// ===== hdl/tmc_pkg.sv =====
`default_nettype none
package tmc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MSS_LIMIT_V4 = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MSS_LIMIT_V6 = 1'b1;

    localparam logic [5:0]  IDX_DATA_OFFSET = 6'd12;
    localparam logic [5:0]  IDX_FLAGS       = 6'd13;
    localparam logic [5:0]  IDX_CSUM_HI     = 6'd16;
    localparam logic [5:0]  IDX_CSUM_LO     = 6'd17;
    localparam logic [5:0]  OPT_START       = 6'd20;
    localparam logic [5:0]  IDX_MAX         = 6'd63;
    localparam logic [7:0]  OPT_KIND_END    = 8'd0;
    localparam logic [7:0]  OPT_KIND_NOP    = 8'd1;
    localparam logic [7:0]  OPT_KIND_MSS    = 8'd2;
    localparam logic [7:0]  MSS_OPT_LEN     = 8'd4;

    typedef enum logic [2:0] {
        PH_KIND,
        PH_LEN,
        PH_MSS_LEN,
        PH_MSS_HI,
        PH_MSS_LO,
        PH_SKIP,
        PH_GOT_MSS
    } t_opt_phase;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       is_last;
        logic       is_ipv6;
    } t_in_item;

    typedef struct packed {
        logic        clamp_applied;
        logic [10:0] new_mss;
        logic [5:0]  mss_offset;
        logic [15:0] new_checksum;
    } t_out_item;

    typedef struct packed {
        logic        ok;
        logic [10:0] limit;
        logic [15:0] mss;
        logic [5:0]  offset;
        logic [15:0] checksum;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage
`default_nettype wire

// ===== hdl/tmc_front.sv =====
`default_nettype none
module tmc_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  tmc_pkg::t_in_item              i_in_item,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [tmc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire [10:0]                     i_cfg_data,
    input  tmc_pkg::t_queue_status         i_queue_status,
    output logic                           o_push,
    output tmc_pkg::t_job                  o_job
);
    import tmc_pkg::*;

    logic [10:0] r_limit_v4;
    logic [10:0] r_limit_v6;
    logic [5:0]  r_byte_index, n_byte_index;
    logic [5:0]  r_header_length, n_header_length;
    logic        r_syn_seen, n_syn_seen;
    logic [15:0] r_checksum, n_checksum;
    t_opt_phase  r_phase, n_phase;
    logic [7:0]  r_skip, n_skip;
    logic [15:0] r_mss, n_mss;
    logic [5:0]  r_offset, n_offset;
    logic        r_walk_done, n_walk_done;

    logic [7:0]  b;
    logic        accept;
    logic        walk_en;
    logic [10:0] limit;

    assign b           = i_in_item.header_byte;
    assign o_in_stall  = i_queue_status.full;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_v4 <= '0;
            r_limit_v6 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MSS_LIMIT_V4: r_limit_v4 <= i_cfg_data;
                CFG_MSS_LIMIT_V6: r_limit_v6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_header_length = r_header_length;
        n_syn_seen      = r_syn_seen;
        n_checksum      = r_checksum;
        case (r_byte_index)
            IDX_DATA_OFFSET: n_header_length = {b[7:4], 2'b00};
            IDX_FLAGS:       n_syn_seen      = b[1];
            IDX_CSUM_HI:     n_checksum      = {b, r_checksum[7:0]};
            IDX_CSUM_LO:     n_checksum      = {r_checksum[15:8], b};
            default: ;
        endcase
        n_byte_index = (r_byte_index < IDX_MAX) ? r_byte_index + 6'd1 : r_byte_index;
    end

    assign walk_en = r_syn_seen && !r_walk_done &&
                     (r_byte_index >= OPT_START) && (r_byte_index < r_header_length);

    // Next option phase.
    always_comb begin
        n_phase = r_phase;
        if (walk_en) begin
            case (r_phase)
                PH_KIND: begin
                    if (b == OPT_KIND_MSS) begin
                        n_phase = PH_MSS_LEN;
                    end else if (!(b inside {OPT_KIND_END, OPT_KIND_NOP})) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (b == 8'd2) begin
                        n_phase = PH_KIND;
                    end else if (b > 8'd2) begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_MSS_LEN: begin
                    if (b == MSS_OPT_LEN) begin
                        n_phase = PH_MSS_HI;
                    end
                end
                PH_MSS_HI: n_phase = PH_MSS_LO;
                PH_MSS_LO: n_phase = PH_GOT_MSS;
                PH_SKIP: begin
                    if (r_skip == 8'd1) begin
                        n_phase = PH_KIND;
                    end
                end
                default: ;
            endcase
        end
    end

    // Data captured while walking the options.
    always_comb begin
        n_skip      = r_skip;
        n_mss       = r_mss;
        n_offset    = r_offset;
        n_walk_done = r_walk_done;
        if (walk_en) begin
            case (r_phase)
                PH_KIND: n_walk_done = (b == OPT_KIND_END);
                PH_LEN: begin
                    if (b inside {8'd0, 8'd1}) begin
                        n_walk_done = 1'b1;
                    end else if (b > 8'd2) begin
                        n_skip = b - 8'd2;
                    end
                end
                PH_MSS_LEN: n_walk_done = (b != MSS_OPT_LEN);
                PH_MSS_HI: begin
                    n_mss    = {b, 8'h00};
                    n_offset = r_byte_index;
                end
                PH_MSS_LO: begin
                    n_mss       = {r_mss[15:8], b};
                    n_walk_done = 1'b1;
                end
                PH_SKIP: n_skip = r_skip - 8'd1;
                default: n_walk_done = 1'b1;
            endcase
        end
    end

    assign limit = i_in_item.is_ipv6 ? r_limit_v6 : r_limit_v4;

    always_comb begin
        o_job.ok       = (limit != 11'd0) && (n_phase == PH_GOT_MSS) &&
                         (n_mss != 16'd0) && (n_mss > {5'd0, limit});
        o_job.limit    = limit;
        o_job.mss      = n_mss;
        o_job.offset   = n_offset;
        o_job.checksum = n_checksum;
    end

    assign o_push = accept && i_in_item.is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in_item.is_last)) begin
            r_byte_index    <= '0;
            r_header_length <= '0;
            r_syn_seen      <= 1'b0;
            r_checksum      <= '0;
            r_phase         <= PH_KIND;
            r_skip          <= '0;
            r_mss           <= '0;
            r_offset        <= '0;
            r_walk_done     <= 1'b0;
        end else if (accept) begin
            r_byte_index    <= n_byte_index;
            r_header_length <= n_header_length;
            r_syn_seen      <= n_syn_seen;
            r_checksum      <= n_checksum;
            r_phase         <= n_phase;
            r_skip          <= n_skip;
            r_mss           <= n_mss;
            r_offset        <= n_offset;
            r_walk_done     <= n_walk_done;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/tmc_queue.sv =====
`default_nettype none
module tmc_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  tmc_pkg::t_job          i_job,
    input  wire                    i_pop,
    output tmc_pkg::t_job          o_job,
    output tmc_pkg::t_queue_status o_status
);
    import tmc_pkg::*;

    t_job                   r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/tmc_back.sv =====
`default_nettype none
module tmc_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  tmc_pkg::t_job          i_job,
    input  tmc_pkg::t_queue_status i_queue_status,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output tmc_pkg::t_out_item     o_out_item
);
    import tmc_pkg::*;

    logic      r_valid;
    t_out_item r_item, n_item;
    logic [17:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    assign o_pop = !i_queue_status.empty && (!r_valid || !i_out_stall);

    // Incremental checksum update in ones' complement arithmetic.
    always_comb begin
        sum   = {2'b00, ~i_job.checksum} + {2'b00, ~i_job.mss} + {7'd0, i_job.limit};
        fold1 = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};
        if (i_job.ok) begin
            n_item.clamp_applied = 1'b1;
            n_item.new_mss       = i_job.limit;
            n_item.mss_offset    = i_job.offset;
            n_item.new_checksum  = ~fold2;
        end else begin
            n_item = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= n_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule
`default_nettype wire

// ===== hdl/tcp_mss_clamp.sv =====
// TCP MSS clamp.
// The input channel takes one TCP header byte per transaction, starting at
// byte 0, with is_last marking the final byte and is_ipv6 giving the IP
// version. One transaction can be accepted in every clock cycle while the
// queue is not full. Exactly one result transaction follows each header:
// when its last byte is accepted, the parser hands a job to a two-entry
// queue, and the result stage registers the checksum update. The two limit
// registers are written through the configuration channel, which is always
// ready; a limit of zero disables clamping for that IP version. Write them
// only while no header is in flight.
// When the receiver stalls, the result holds in the output register and the
// queue absorbs up to two further finished headers; once the queue is full,
// the input channel is stalled. Reset clears the limits, the parser state,
// the queue and the output valid flag.
`default_nettype none
module tcp_mss_clamp (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  tmc_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output tmc_pkg::t_out_item             o_out_item,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [tmc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire [10:0]                     i_cfg_data
);
    import tmc_pkg::*;

    t_job          push_job;
    t_job          head_job;
    t_queue_status queue_status;
    logic          push;
    logic          pop;

    tmc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_item      (i_in_item),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_queue_status (queue_status),
        .o_push         (push),
        .o_job          (push_job)
    );

    tmc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (queue_status)
    );

    tmc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (head_job),
        .i_queue_status (queue_status),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_item     (o_out_item)
    );

endmodule
`default_nettype wire

// ===== hdl/tmc_checker.sv =====
`default_nettype none
`include "tcp_mss_clamp_macros.svh"
module tmc_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    input  wire                            o_in_stall,
    input  tmc_pkg::t_in_item              i_in_item,
    input  wire                            o_out_valid,
    input  wire                            i_out_stall,
    input  tmc_pkg::t_out_item             o_out_item,
    input  wire                            i_cfg_valid,
    input  wire                            o_cfg_ready,
    input  wire [tmc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire [10:0]                     i_cfg_data
);
    import tmc_pkg::*;

    logic unused_inputs;
    assign unused_inputs = ^{i_in_valid, o_in_stall, i_in_item, i_cfg_valid,
                             o_cfg_ready, i_cfg_index, i_cfg_data};

    `TMC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `TMC_ASSERT_SAME(a_no_clamp_zero, o_out_valid && !o_out_item.clamp_applied, o_out_item.new_mss == 11'd0 && o_out_item.mss_offset == 6'd0 && o_out_item.new_checksum == 16'd0)
    `TMC_ASSERT_SAME(a_clamp_fields, o_out_valid && o_out_item.clamp_applied, o_out_item.new_mss != 11'd0 && o_out_item.mss_offset >= 6'd22)

endmodule

bind tcp_mss_clamp tmc_checker u_tmc_checker (.*);
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import tmc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_BYTES    = 60;

    class tmc_scoreboard;
        logic [10:0] limit_v4;
        logic [10:0] limit_v6;
        logic [5:0]  byte_pos;
        logic [5:0]  hdr_len;
        logic        syn;
        logic [15:0] csum;
        t_opt_phase  phase;
        logic [7:0]  skip_left;
        logic [15:0] mss;
        logic [5:0]  mss_pos;
        logic        done;
        t_out_item   pending[$];
        int          errors;
        int          bytes_seen;
        int          results_seen;
        int          clamps_seen;

        function new();
            limit_v4 = '0;
            limit_v6 = '0;
            errors = 0;
            bytes_seen = 0;
            results_seen = 0;
            clamps_seen = 0;
            clear();
        endfunction

        function void clear();
            byte_pos = '0;
            hdr_len = '0;
            syn = 1'b0;
            csum = '0;
            phase = PH_KIND;
            skip_left = '0;
            mss = '0;
            mss_pos = '0;
            done = 1'b0;
        endfunction

        function void set_limit(logic [CFG_INDEX_W-1:0] idx, logic [10:0] val);
            if (idx == CFG_MSS_LIMIT_V4) begin
                limit_v4 = val;
            end else if (idx == CFG_MSS_LIMIT_V6) begin
                limit_v6 = val;
            end
        endfunction

        function void walk_option(logic [7:0] b, logic [5:0] idx);
            case (phase)
                PH_KIND: begin
                    if (b == OPT_KIND_END) begin
                        done = 1'b1;
                    end else if (b == OPT_KIND_MSS) begin
                        phase = PH_MSS_LEN;
                    end else if (b != OPT_KIND_NOP) begin
                        phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (b < 8'd2) begin
                        done = 1'b1;
                    end else if (b == 8'd2) begin
                        phase = PH_KIND;
                    end else begin
                        skip_left = b - 8'd2;
                        phase = PH_SKIP;
                    end
                end
                PH_MSS_LEN: begin
                    if (b == MSS_OPT_LEN) begin
                        phase = PH_MSS_HI;
                    end else begin
                        done = 1'b1;
                    end
                end
                PH_MSS_HI: begin
                    mss = {b, 8'h00};
                    mss_pos = idx;
                    phase = PH_MSS_LO;
                end
                PH_MSS_LO: begin
                    mss[7:0] = b;
                    phase = PH_GOT_MSS;
                    done = 1'b1;
                end
                PH_SKIP: begin
                    skip_left = skip_left - 8'd1;
                    if (skip_left == 8'd0) begin
                        phase = PH_KIND;
                    end
                end
                default: begin
                    done = 1'b1;
                end
            endcase
        endfunction

        function void note_byte(t_in_item it);
            logic [5:0]  idx;
            logic [7:0]  b;
            logic [10:0] lim;
            logic [31:0] s;
            t_out_item   want;
            idx = byte_pos;
            b = it.header_byte;
            bytes_seen++;
            case (idx)
                IDX_DATA_OFFSET: hdr_len = {b[7:4], 2'b00};
                IDX_FLAGS:       syn = b[1];
                IDX_CSUM_HI:     csum[15:8] = b;
                IDX_CSUM_LO:     csum[7:0] = b;
                default: ;
            endcase
            if (syn && !done && idx >= OPT_START && idx < hdr_len) begin
                walk_option(b, idx);
            end
            if (byte_pos < IDX_MAX) begin
                byte_pos = byte_pos + 6'd1;
            end
            if (!it.is_last) begin
                return;
            end
            lim = it.is_ipv6 ? limit_v6 : limit_v4;
            want = '0;
            if (lim != 0 && phase == PH_GOT_MSS && mss != 0 && mss > {5'b0, lim}) begin
                s = {16'h0, ~csum} + {16'h0, ~mss} + {21'h0, lim};
                s = (s & 32'hffff) + (s >> 16);
                s = (s & 32'hffff) + (s >> 16);
                want.clamp_applied = 1'b1;
                want.new_mss = lim;
                want.mss_offset = mss_pos;
                want.new_checksum = ~s[15:0];
            end
            pending.push_back(want);
            clear();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report("result transaction with no header outstanding");
                return;
            end
            want = pending.pop_front();
            results_seen++;
            if (want.clamp_applied) begin
                clamps_seen++;
            end
            if (got.clamp_applied !== want.clamp_applied) begin
                report($sformatf("clamp_applied got %b want %b",
                                 got.clamp_applied, want.clamp_applied));
            end
            if (got.new_mss !== want.new_mss) begin
                report($sformatf("new_mss got %0d want %0d", got.new_mss, want.new_mss));
            end
            if (got.mss_offset !== want.mss_offset) begin
                report($sformatf("mss_offset got %0d want %0d",
                                 got.mss_offset, want.mss_offset));
            end
            if (got.new_checksum !== want.new_checksum) begin
                report($sformatf("new_checksum got %h want %h",
                                 got.new_checksum, want.new_checksum));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    t_in_item               i_in_item = '0;
    logic                   i_out_stall = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [10:0]            i_cfg_data = '0;
    wire                    o_in_stall;
    wire                    o_out_valid;
    wire                    o_cfg_ready;
    t_out_item              o_out_item;

    tmc_scoreboard sb = new();
    logic [7:0]    hdr[$];
    logic          hdr_v6;
    bit            calm = 1'b0;
    int            idle_cycles = 0;
    int            stall_left = 0;
    int            headers_sent = 0;

    tcp_mss_clamp dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_byte(i_in_item);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_item);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_limit(i_cfg_index, i_cfg_data);
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18);
        end
        i_out_stall = (stall_left > 0);
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    task write_limit(logic [CFG_INDEX_W-1:0] idx, logic [10:0] val);
        i_cfg_index = idx;
        i_cfg_data = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task set_limits(logic [10:0] v4, logic [10:0] v6);
        while (sb.pending.size() != 0) @(negedge i_clk);
        write_limit(CFG_MSS_LIMIT_V4, v4);
        write_limit(CFG_MSS_LIMIT_V6, v6);
    endtask

    task send_byte(t_in_item it);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid = 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge i_clk);
        end
        i_in_item = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task send_header(int len, logic v6);
        t_in_item it;
        while (hdr.size() < len) hdr.push_back(8'($urandom));
        while (hdr.size() > len) void'(hdr.pop_back());
        for (int i = 0; i < hdr.size(); i++) begin
            it.header_byte = hdr[i];
            it.is_last = (i == hdr.size() - 1);
            it.is_ipv6 = it.is_last ? v6 : 1'($urandom);
            send_byte(it);
        end
        i_in_valid = 1'b0;
        headers_sent++;
    endtask

    task fixed_head(int doff, bit with_syn, logic [15:0] cs);
        hdr.delete();
        repeat (12) hdr.push_back(8'($urandom));
        hdr.push_back({4'(doff), 4'($urandom)});
        hdr.push_back(with_syn ? 8'h12 : 8'h10);
        repeat (2) hdr.push_back(8'($urandom));
        hdr.push_back(cs[15:8]);
        hdr.push_back(cs[7:0]);
        repeat (2) hdr.push_back(8'($urandom));
    endtask

    task push_mss(logic [7:0] len, logic [15:0] val);
        hdr.push_back(OPT_KIND_MSS);
        hdr.push_back(len);
        hdr.push_back(val[15:8]);
        hdr.push_back(val[7:0]);
    endtask

    function logic [15:0] pick_mss(logic [10:0] lim);
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return {5'b0, lim} + 16'd1;
            2: return {5'b0, lim};
            3: return 16'($urandom_range(1500, 65535));
            4: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            default: return 16'($urandom_range(1, 1600));
        endcase
    endfunction

    task make_header();
        int doff;
        int hlen;
        int len;
        int l;
        bit placed;
        int r;
        hdr.delete();
        hdr_v6 = 1'($urandom);
        r = $urandom_range(0, 19);
        if (r == 0) begin
            len = $urandom_range(1, 19);
            repeat (len) hdr.push_back(8'($urandom));
            return;
        end
        repeat (12) hdr.push_back(8'($urandom));
        if (r < 4) begin
            doff = $urandom_range(0, 15);
            repeat (8) hdr.push_back(8'($urandom));
            hlen = doff * 4;
            while (hdr.size() < hlen) hdr.push_back(8'($urandom));
        end else begin
            doff = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(6, 10);
            hlen = doff * 4;
            hdr.push_back({4'(doff), 4'($urandom)});
            if ($urandom_range(0, 9) == 0) begin
                hdr.push_back(8'($urandom) & 8'hfd);
            end else begin
                hdr.push_back(8'($urandom) | 8'h02);
            end
            repeat (6) hdr.push_back(8'($urandom));
            placed = 1'b0;
            while (hdr.size() < hlen) begin
                r = $urandom_range(0, 9);
                if (!placed && (r < 4 || hdr.size() + 4 >= hlen)) begin
                    placed = 1'b1;
                    push_mss(($urandom_range(0, 11) == 0) ? 8'($urandom) : MSS_OPT_LEN,
                             pick_mss(hdr_v6 ? sb.limit_v6 : sb.limit_v4));
                end else if (r < 7) begin
                    hdr.push_back(OPT_KIND_NOP);
                end else if (r < 9) begin
                    l = $urandom_range(2, 6);
                    hdr.push_back(8'($urandom_range(3, 255)));
                    hdr.push_back(8'(l));
                    repeat (l - 2) hdr.push_back(8'($urandom));
                end else begin
                    hdr.push_back(($urandom_range(0, 3) == 0) ? OPT_KIND_END : 8'($urandom));
                end
            end
        end
        len = (hlen > 20) ? hlen : 20;
        while (hdr.size() > len) void'(hdr.pop_back());
        r = $urandom_range(0, 9);
        if (r == 0) begin
            len = $urandom_range(1, len);
        end else if (r == 1) begin
            len = $urandom_range(len + 1, 70);
        end
        while (hdr.size() < len) hdr.push_back(8'($urandom));
        while (hdr.size() > len) void'(hdr.pop_back());
    endtask

    task random_phase(int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            make_header();
            sent += hdr.size();
            send_header(hdr.size(), hdr_v6);
        end
    endtask

    initial begin
        logic [10:0] v4s[5];
        logic [10:0] v6s[5];
        v4s = '{11'd1500, 11'd536, 11'd0, 11'd1023, 11'($urandom_range(0, 1500))};
        v6s = '{11'd1, 11'd1220, 11'd1500, 11'd0, 11'($urandom_range(0, 1500))};
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        fixed_head(6, 1, 16'h1234);
        push_mss(MSS_OPT_LEN, 16'd1460);
        send_header(24, 1'b0);

        set_limits(11'd1000, 11'd1500);
        fixed_head(6, 1, 16'hffff);
        push_mss(MSS_OPT_LEN, 16'hffff);
        send_header(24, 1'b0);
        fixed_head(6, 1, 16'h0000);
        push_mss(MSS_OPT_LEN, 16'hffff);
        send_header(24, 1'b1);
        fixed_head(6, 1, 16'h8001);
        push_mss(MSS_OPT_LEN, 16'h0000);
        send_header(24, 1'b0);
        fixed_head(6, 1, 16'h4321);
        push_mss(MSS_OPT_LEN, 16'd1000);
        send_header(24, 1'b0);
        fixed_head(6, 0, 16'h4321);
        push_mss(MSS_OPT_LEN, 16'd1460);
        send_header(24, 1'b0);
        fixed_head(5, 1, 16'h4321);
        push_mss(MSS_OPT_LEN, 16'd1460);
        send_header(24, 1'b0);
        fixed_head(8, 1, 16'h00ff);
        hdr.push_back(OPT_KIND_NOP);
        hdr.push_back(8'd3);
        hdr.push_back(8'd3);
        hdr.push_back(8'hff);
        hdr.push_back(8'd4);
        hdr.push_back(8'd2);
        push_mss(MSS_OPT_LEN, 16'd1460);
        send_header(32, 1'b0);
        fixed_head(7, 1, 16'h5a5a);
        hdr.push_back(8'd8);
        hdr.push_back(8'd1);
        push_mss(MSS_OPT_LEN, 16'd1460);
        send_header(28, 1'b0);
        fixed_head(7, 1, 16'h5a5a);
        push_mss(8'd5, 16'd1460);
        send_header(28, 1'b0);
        fixed_head(6, 1, 16'h5a5a);
        hdr.push_back(OPT_KIND_NOP);
        hdr.push_back(OPT_KIND_NOP);
        push_mss(MSS_OPT_LEN, 16'd1460);
        send_header(26, 1'b0);
        fixed_head(6, 1, 16'h5a5a);
        push_mss(MSS_OPT_LEN, 16'd1460);
        send_header(23, 1'b0);
        fixed_head(7, 1, 16'h5a5a);
        hdr.push_back(OPT_KIND_END);
        push_mss(MSS_OPT_LEN, 16'd1460);
        send_header(28, 1'b0);
        fixed_head(15, 1, 16'hfffe);
        repeat (36) hdr.push_back(OPT_KIND_NOP);
        push_mss(MSS_OPT_LEN, 16'd9000);
        send_header(70, 1'b1);

        set_limits(11'd1, 11'd0);
        fixed_head(6, 1, 16'h1111);
        push_mss(MSS_OPT_LEN, 16'hffff);
        send_header(24, 1'b1);
        fixed_head(6, 1, 16'h1111);
        push_mss(MSS_OPT_LEN, 16'd2);
        send_header(24, 1'b0);

        for (int p = 0; p < 5; p++) begin
            set_limits(v4s[p], v6s[p]);
            calm = (p == 4);
            random_phase(PHASE_BYTES);
        end

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (sb.pending.size() != 0) begin
            sb.report("headers left without a result");
        end
        $display("Sent %0d headers (%0d bytes) over eight limit settings.",
                 headers_sent, sb.bytes_seen);
        $display("Checked %0d results, %0d of them with the MSS clamped.",
                 sb.results_seen, sb.clamps_seen);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/tmc_pkg.sv
hdl/tmc_front.sv
hdl/tmc_queue.sv
hdl/tmc_back.sv
hdl/tcp_mss_clamp.sv
hdl/tmc_checker.sv
sim/testbench.sv
